// ===== hdl/kbw_pkg.sv =====
`default_nettype none

package kbw_pkg;

    // reply status codes
    localparam logic [2:0] ST_CHAR    = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_FAIL    = 3'd2;
    localparam logic [2:0] ST_KEY     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    // request kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_CLAIM = 2'd1;

    localparam int ID_W   = 16;
    localparam int CHAR_W = 8;
    localparam int IX_W   = 8;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    // slot index carried at its widest; the store takes the low bits it needs
    typedef struct packed {
        logic              owner_en;
        logic              char_en;
        logic [IX_W-1:0]   addr;
        logic [ID_W-1:0]   owner;
        logic [CHAR_W-1:0] chr;
    } t_slot_wr;

endpackage

`default_nettype wire

// ===== hdl/kbw_ring.sv =====
`default_nettype none

module kbw_ring
    import kbw_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int W     = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_ring_ctl        i_ctl,
    input  wire logic [W-1:0]     i_wdata,
    output logic                  o_empty,
    output logic                  o_full,
    output logic [$clog2(DEPTH):0] o_count,
    output logic [W-1:0]          o_tail_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] L_LAST  = AW'(DEPTH - 1);
    localparam logic [AW:0]   L_DEPTH = (AW + 1)'(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [W-1:0]  r_tail_q;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [AW-1:0] w_head_inc;
    logic [AW-1:0] w_tail_inc;

    assign w_head_inc = (r_head == L_LAST) ? '0 : r_head + 1'b1;
    assign w_tail_inc = (r_tail == L_LAST) ? '0 : r_tail + 1'b1;
    assign n_head     = i_ctl.push ? w_head_inc : r_head;
    assign n_tail     = i_ctl.pop  ? w_tail_inc : r_tail;

    assign o_empty = (r_head == r_tail);
    assign o_full  = (w_head_inc == r_tail);
    assign o_count = (r_head >= r_tail) ? {1'b0, r_head} - {1'b0, r_tail}
                                        : {1'b0, r_head} + L_DEPTH - {1'b0, r_tail};
    assign o_tail_data = r_tail_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // the entry at the next tail position is registered in advance; a write landing there is forwarded
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_head] <= i_wdata;
        end
        if (i_ctl.push && (r_head == n_tail)) begin
            r_tail_q <= i_wdata;
        end else begin
            r_tail_q <= r_mem[n_tail];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kbw_slot_store.sv =====
`default_nettype none

module kbw_slot_store
    import kbw_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [IX_W-1:0]   i_rd_addr,
    input  wire t_slot_wr          i_wr,
    output logic [ID_W-1:0]        o_owner,
    output logic [CHAR_W-1:0]      o_char
);

    localparam int AW = $clog2(DEPTH);

    logic [ID_W-1:0]   r_owner_mem [DEPTH];
    logic [CHAR_W-1:0] r_char_mem  [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [ID_W-1:0]   r_owner_q;
    logic [CHAR_W-1:0] r_char_q;
    logic [AW-1:0]     w_wa;
    logic [AW-1:0]     w_ra;

    assign w_wa    = i_wr.addr[AW-1:0];
    assign w_ra    = i_rd_addr[AW-1:0];
    assign o_owner = r_owner_q;
    assign o_char  = r_char_q;

    // a slot reads as free with char zero until a keystroke first fills it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.char_en) begin
            r_vld[w_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.owner_en) begin
            r_owner_mem[w_wa] <= i_wr.owner;
        end
        if (i_wr.char_en) begin
            r_char_mem[w_wa] <= i_wr.chr;
        end
        if (i_rd_en) begin
            if (i_wr.owner_en && (w_wa == w_ra)) begin
                r_owner_q <= i_wr.owner;
            end else if (r_vld[w_ra]) begin
                r_owner_q <= r_owner_mem[w_ra];
            end else begin
                r_owner_q <= '0;
            end
            if (i_wr.char_en && (w_wa == w_ra)) begin
                r_char_q <= i_wr.chr;
            end else if (r_vld[w_ra]) begin
                r_char_q <= r_char_mem[w_ra];
            end else begin
                r_char_q <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/keystroke_buffer_with_waiters_unit.sv =====
`default_nettype none
// Channel   Dir  Handshake                      Payload (low bit up)
// request   in   s_axis_tvalid/s_axis_tready    tdata: requester_id, key_char, sem_id,
//                                               slot_index; tuser: mode
// reply     out  m_axis_tvalid/m_axis_tready    tdata: reply_to, reply_value, wake,
//                                               wake_sem; tuser: status
// config    in   i_cfg_wr_en                    i_cfg_wr_data: keyboard_source_id
//
// One transaction per cycle while the reply is not stalled; a taken request enters the
// input register, with the slot-store read registered alongside it, then moves into
// the reply register.
// A stalled reply holds the request stage; ring and slot state changes only when a
// request moves into the reply register. Reset is synchronous, active low, and needs
// no clearing pass: slot entries carry valid bits.

module keystroke_buffer_with_waiters_unit
    import kbw_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // requester_id, key_char, sem_id, slot_index
    input  wire logic [1:0]  s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // reply_to, reply_value, wake, wake_sem, pad
    output logic [2:0]       m_axis_tuser,   // status
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] L_LAST  = AW'(DEPTH - 1);
    localparam logic [AW:0]   L_DEPTH = (AW + 1)'(DEPTH);
    localparam logic [IX_W:0] L_IX_LIM = (IX_W + 1)'(DEPTH);

    logic [ID_W-1:0]   r_kbd_src;

    logic              r_a_vld;
    logic [ID_W-1:0]   r_a_req;
    logic [1:0]        r_a_mode;
    logic [CHAR_W-1:0] r_a_key;
    logic [ID_W-1:0]   r_a_sem;
    logic [IX_W-1:0]   r_a_ix;

    logic              r_o_vld;
    logic [ID_W-1:0]   r_o_reply_to;
    logic [2:0]        r_o_status;
    logic [CHAR_W-1:0] r_o_value;
    logic              r_o_wake;
    logic [ID_W-1:0]   r_o_wake_sem;

    logic [AW-1:0]     r_slot_next;

    logic              w_fire;
    logic              w_acc;
    logic [2:0]        n_status;
    logic [CHAR_W-1:0] n_value;
    logic              n_wake;
    logic [ID_W-1:0]   n_wake_sem;
    logic              n_slot_adv;
    t_ring_ctl         w_cr_ctl;
    t_ring_ctl         w_wr_ctl;
    t_slot_wr          w_slot_wr;

    logic              w_cr_empty;
    logic              w_cr_full;
    logic [CHAR_W-1:0] w_cr_tail;
    logic              w_wt_empty;
    logic              w_wt_full;
    logic [AW:0]       w_wt_count;
    logic [2*ID_W-1:0] w_wt_tail;
    logic [ID_W-1:0]   w_slot_owner;
    logic [CHAR_W-1:0] w_slot_char;
    logic [AW:0]       w_wait_sum;
    logic [AW:0]       w_wait_slot;
    logic              w_ix_ok;

    assign w_fire        = r_a_vld && (!r_o_vld || m_axis_tready);
    assign s_axis_tready = !r_a_vld || w_fire;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    kbw_ring #(.DEPTH(DEPTH), .W(CHAR_W)) u_char_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_cr_ctl),
        .i_wdata     (r_a_key),
        .o_empty     (w_cr_empty),
        .o_full      (w_cr_full),
        .o_count     (),
        .o_tail_data (w_cr_tail)
    );

    // entry: {sem, id}
    kbw_ring #(.DEPTH(DEPTH), .W(2*ID_W)) u_waiter_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_wr_ctl),
        .i_wdata     ({r_a_sem, r_a_req}),
        .o_empty     (w_wt_empty),
        .o_full      (w_wt_full),
        .o_count     (w_wt_count),
        .o_tail_data (w_wt_tail)
    );

    kbw_slot_store #(.DEPTH(DEPTH)) u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_addr (s_axis_tdata[47:40]),
        .i_wr      (w_slot_wr),
        .o_owner   (w_slot_owner),
        .o_char    (w_slot_char)
    );

    // slot a new waiter will be handed: slot_next plus waiters already queued
    assign w_wait_sum  = {1'b0, r_slot_next} + w_wt_count;
    assign w_wait_slot = (w_wait_sum >= L_DEPTH) ? w_wait_sum - L_DEPTH : w_wait_sum;
    assign w_ix_ok     = ({1'b0, r_a_ix} < L_IX_LIM);

    always_comb begin
        n_status   = ST_UNKNOWN;
        n_value    = '0;
        n_wake     = 1'b0;
        n_wake_sem = '0;
        n_slot_adv = 1'b0;
        w_cr_ctl   = '0;
        w_wr_ctl   = '0;
        w_slot_wr  = '0;
        w_slot_wr.addr = r_a_ix;
        if (r_a_req == r_kbd_src) begin
            n_status = ST_KEY;
            if (!w_wt_empty) begin
                n_wake          = 1'b1;
                n_wake_sem      = w_wt_tail[2*ID_W-1:ID_W];
                w_slot_wr.owner_en = w_fire;
                w_slot_wr.char_en  = w_fire;
                w_slot_wr.addr  = IX_W'(r_slot_next);
                w_slot_wr.owner = w_wt_tail[ID_W-1:0];
                w_slot_wr.chr   = r_a_key;
                w_wr_ctl.pop    = w_fire;
                n_slot_adv      = w_fire;
            end else begin
                // full ring drops its oldest char
                w_cr_ctl.push = w_fire;
                w_cr_ctl.pop  = w_fire && w_cr_full;
            end
        end else begin
            case (r_a_mode)
                MODE_READ: begin
                    if (!w_cr_empty) begin
                        n_status     = ST_CHAR;
                        n_value      = w_cr_tail;
                        w_cr_ctl.pop = w_fire;
                    end else if (w_wt_full) begin
                        n_status = ST_FAIL;
                    end else begin
                        n_status      = ST_WAIT;
                        n_value       = CHAR_W'(w_wait_slot[AW-1:0]);
                        w_wr_ctl.push = w_fire;
                    end
                end
                MODE_CLAIM: begin
                    if (!w_ix_ok || (w_slot_owner != r_a_req)) begin
                        n_status = ST_FAIL;
                    end else begin
                        n_status           = ST_CHAR;
                        n_value            = w_slot_char;
                        w_slot_wr.owner_en = w_fire;
                        w_slot_wr.owner    = '0;
                    end
                end
                default: begin
                    n_status = ST_UNKNOWN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbd_src   <= '0;
            r_a_vld     <= 1'b0;
            r_o_vld     <= 1'b0;
            r_slot_next <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_kbd_src <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_a_vld <= s_axis_tvalid;
            end
            if (w_fire) begin
                r_o_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
            if (n_slot_adv) begin
                r_slot_next <= (r_slot_next == L_LAST) ? '0 : r_slot_next + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_req  <= s_axis_tdata[15:0];
            r_a_key  <= s_axis_tdata[23:16];
            r_a_sem  <= s_axis_tdata[39:24];
            r_a_ix   <= s_axis_tdata[47:40];
            r_a_mode <= s_axis_tuser;
        end
        if (w_fire) begin
            r_o_reply_to <= r_a_req;
            r_o_status   <= n_status;
            r_o_value    <= n_value;
            r_o_wake     <= n_wake;
            r_o_wake_sem <= n_wake_sem;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {7'd0, r_o_wake_sem, r_o_wake, r_o_value, r_o_reply_to};

endmodule

`default_nettype wire

// ===== hdl/kbw_checker.sv =====
`default_nettype none

module kbw_checker
    import kbw_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // stalled reply keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("reply changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_UNKNOWN))
        else $error("status code out of range");

    // only a keystroke wakes a waiter; otherwise the semaphore field is zero
    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[24] ? (m_axis_tuser == ST_KEY)
                                            : (m_axis_tdata[40:25] == 16'd0)))
        else $error("wake inconsistent with status");

    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FAIL || m_axis_tuser == ST_KEY
            || m_axis_tuser == ST_UNKNOWN) |-> (m_axis_tdata[23:16] == 8'd0))
        else $error("reply value set on a status that carries none");

    // nothing emerges in the cycle after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("reply valid right after reset");

endmodule

bind keystroke_buffer_with_waiters_unit kbw_checker u_kbw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import kbw_pkg::*;

    localparam int DEPTH = 16;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES = 4;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [1:0] MODE_RSVD_A = 2'd2;
    localparam logic [1:0] MODE_RSVD_B = 2'd3;
    localparam int NUM_CLIENTS = 8;

    typedef struct packed {
        logic [15:0] reply_to;
        logic [2:0]  status;
        logic [7:0]  value;
        logic        wake;
        logic [15:0] wake_sem;
    } t_kbw_reply;

    // Mirror of the broker: char ring, waiter ring, outbox slots.
    class kbw_scoreboard;
        logic [15:0] kbd_id;
        logic [7:0]  chars[DEPTH];
        logic [3:0]  ch_head, ch_tail;
        logic [15:0] w_ids[DEPTH];
        logic [15:0] w_sems[DEPTH];
        logic [3:0]  w_head, w_tail;
        logic [15:0] owner[DEPTH];
        logic [7:0]  slot_chr[DEPTH];
        logic [3:0]  slot_next;
        t_kbw_reply  pending_replies[$];
        int          errors;
        int          requests;
        int          status_seen[5];

        function new();
            kbd_id = '0;
            ch_head = '0;
            ch_tail = '0;
            w_head = '0;
            w_tail = '0;
            slot_next = '0;
            errors = 0;
            requests = 0;
            for (int i = 0; i < DEPTH; i++) begin
                chars[i] = '0;
                w_ids[i] = '0;
                w_sems[i] = '0;
                owner[i] = '0;
                slot_chr[i] = '0;
            end
            for (int i = 0; i < 5; i++) status_seen[i] = 0;
        endfunction

        function void set_source(logic [15:0] id);
            kbd_id = id;
        endfunction

        // 4-bit indices wrap at DEPTH; one entry of each ring stays unused
        function void note_request(logic [15:0] req, logic [1:0] mode, logic [7:0] key,
                                   logic [15:0] sem, logic [7:0] ix);
            t_kbw_reply r;
            logic [3:0] w_count;
            r = '0;
            r.reply_to = req;
            w_count = w_head - w_tail;
            requests++;
            if (req == kbd_id) begin
                r.status = ST_KEY;
                if (w_count != 0) begin
                    r.wake = 1'b1;
                    r.wake_sem = w_sems[w_tail];
                    owner[slot_next] = w_ids[w_tail];
                    slot_chr[slot_next] = key;
                    w_tail++;
                    slot_next++;
                end else begin
                    chars[ch_head] = key;
                    if (4'(ch_tail - ch_head - 1) == 0) ch_tail++;
                    ch_head++;
                end
            end else if (mode == MODE_READ) begin
                if (ch_head != ch_tail) begin
                    r.status = ST_CHAR;
                    r.value = chars[ch_tail];
                    ch_tail++;
                end else if (4'(w_tail - w_head - 1) == 0) begin
                    r.status = ST_FAIL;
                end else begin
                    w_ids[w_head] = req;
                    w_sems[w_head] = sem;
                    r.status = ST_WAIT;
                    r.value = 8'(4'(slot_next + w_count));
                    w_head++;
                end
            end else if (mode == MODE_CLAIM) begin
                if (ix >= DEPTH || owner[ix[3:0]] != req) begin
                    r.status = ST_FAIL;
                end else begin
                    r.status = ST_CHAR;
                    r.value = slot_chr[ix[3:0]];
                    owner[ix[3:0]] = '0;
                end
            end else begin
                r.status = ST_UNKNOWN;
            end
            pending_replies.push_back(r);
        endfunction

        function void flag(string what, logic [15:0] exp_v, logic [15:0] got_v);
            errors++;
            if (errors <= 10)
                $display("%0t: reply %s mismatch: expected %h, got %h", $time, what,
                         exp_v, got_v);
        endfunction

        function void check_reply(t_kbw_reply got);
            t_kbw_reply exp;
            if (pending_replies.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: reply with none outstanding: %p", $time, got);
                return;
            end
            exp = pending_replies.pop_front();
            if (got.status <= ST_UNKNOWN) status_seen[got.status]++;
            if (got.reply_to !== exp.reply_to) flag("reply_to", exp.reply_to, got.reply_to);
            if (got.status !== exp.status) flag("status", 16'(exp.status), 16'(got.status));
            if (got.value !== exp.value) flag("value", 16'(exp.value), 16'(got.value));
            if (got.wake !== exp.wake) flag("wake", 16'(exp.wake), 16'(got.wake));
            if (got.wake_sem !== exp.wake_sem) flag("wake_sem", exp.wake_sem, got.wake_sem);
        endfunction

        function bit find_owned(output logic [3:0] slot);
            int start;
            start = $urandom_range(0, DEPTH - 1);
            for (int i = 0; i < DEPTH; i++) begin
                slot = 4'(start + i);
                if (owner[slot] != 0) return 1'b1;
            end
            return 1'b0;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // requester_id, key_char, sem_id, slot_index
    logic [1:0]  s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // reply_to, reply_value, wake, wake_sem, pad
    logic [2:0]  m_axis_tuser;   // status
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    kbw_scoreboard sb;
    int          idle_pct;
    int          stall_pct;
    logic [15:0] clients[NUM_CLIENTS];

    keystroke_buffer_with_waiters_unit #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // replies are checked before this edge's request is noted; latency keeps them apart
    always @(posedge i_clk) begin
        t_kbw_reply got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.reply_to = m_axis_tdata[15:0];
                got.value    = m_axis_tdata[23:16];
                got.wake     = m_axis_tdata[24];
                got.wake_sem = m_axis_tdata[40:25];
                got.status   = m_axis_tuser;
                sb.check_reply(got);
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[15:0], s_axis_tuser, s_axis_tdata[23:16],
                                s_axis_tdata[39:24], s_axis_tdata[47:40]);
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_request(logic [15:0] req, logic [1:0] mode, logic [7:0] key,
                                logic [15:0] sem, logic [7:0] ix);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ix, sem, key, req};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_all_replies();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_source(logic [15:0] id);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= id;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_source(id);
        @(negedge i_clk);
    endtask

    task automatic send_key(logic [7:0] key);
        send_request(sb.kbd_id, 2'($urandom), key, 16'($urandom), 8'($urandom));
    endtask

    // one random step; returns the number of requests sent
    task automatic random_step(output int sent);
        int          r;
        int          len;
        logic [3:0]  slot;
        logic [15:0] who;
        r = $urandom_range(0, 99);
        sent = 1;
        who = clients[$urandom_range(0, NUM_CLIENTS - 1)];
        if (r < 25) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) send_key(8'($urandom));
            sent = len;
        end else if (r < 50) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
                send_request(clients[$urandom_range(0, NUM_CLIENTS - 1)], MODE_READ,
                             8'($urandom), 16'($urandom), 8'($urandom));
            sent = len;
        end else if (r < 75) begin
            if (sb.find_owned(slot))
                send_request(sb.owner[slot], MODE_CLAIM, 8'($urandom), 16'($urandom),
                             8'(slot));
            else
                send_request(who, MODE_READ, 8'($urandom), 16'($urandom), 8'($urandom));
        end else if (r < 82) begin
            send_request(who, MODE_CLAIM, 8'($urandom), 16'($urandom),
                         8'($urandom_range(0, DEPTH - 1)));
        end else if (r < 87) begin
            send_request(16'($urandom), MODE_CLAIM, 8'($urandom), 16'($urandom),
                         8'($urandom));
        end else if (r < 91 && sb.kbd_id != 0) begin
            send_request(16'h0000, MODE_CLAIM, 8'($urandom), 16'($urandom),
                         8'($urandom_range(0, DEPTH - 1)));
        end else if (r < 95) begin
            send_request(16'($urandom),
                         ($urandom_range(0, 1) != 0) ? MODE_RSVD_A : MODE_RSVD_B,
                         8'($urandom), 16'($urandom), 8'($urandom));
        end else begin
            send_request(16'($urandom), 2'($urandom), 8'($urandom), 16'($urandom),
                         8'($urandom));
        end
    endtask

    initial begin
        logic [15:0] src;
        int          n;
        int          sent;
        sb = new();
        clients = '{16'h0001, 16'h0002, 16'h0003, 16'h1234,
                    16'h8000, 16'hFFFE, 16'h7FFF, 16'h0101};
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: handoff to waiters, claims, ring buffering, odd requests
        write_source(16'h00A5);
        send_request(16'h0001, MODE_READ, 8'h00, 16'hFFFF, 8'h00);
        send_request(16'h0002, MODE_READ, 8'hFF, 16'h0000, 8'hFF);
        send_request(16'h00A5, MODE_RSVD_B, 8'hFF, 16'hFFFF, 8'hFF);
        send_request(16'h00A5, MODE_CLAIM, 8'h00, 16'h0000, 8'h00);
        send_request(16'h0002, MODE_CLAIM, 8'h00, 16'h0000, 8'h00);   // not the owner
        send_request(16'h0001, MODE_CLAIM, 8'h00, 16'h0000, 8'h00);
        send_request(16'h0001, MODE_CLAIM, 8'h00, 16'h0000, 8'h00);   // already freed
        send_request(16'h0002, MODE_CLAIM, 8'h00, 16'h0000, 8'hFF);   // out of range
        send_request(16'h0002, MODE_CLAIM, 8'h00, 16'h0000, 8'(DEPTH));
        send_request(16'h0002, MODE_CLAIM, 8'h00, 16'h0000, 8'h01);
        send_request(16'h0000, MODE_CLAIM, 8'h00, 16'h0000, 8'h00);   // zero id hits free slot
        send_request(16'h0003, MODE_RSVD_A, 8'hFF, 16'hFFFF, 8'hFF);
        send_request(16'hFFFF, MODE_RSVD_B, 8'h00, 16'h0000, 8'h00);
        send_key(8'h41);
        send_key(8'h42);
        send_request(16'h0003, MODE_READ, 8'h00, 16'h0000, 8'h00);
        send_request(16'hFFFF, MODE_READ, 8'h00, 16'h0000, 8'h00);
        send_request(16'h0001, MODE_READ, 8'h00, 16'hA5A5, 8'h00);
        send_key(8'h5A);
        send_request(16'h0001, MODE_CLAIM, 8'h00, 16'h0000, 8'h02);
        wait_all_replies();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    src = 16'h0000;
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    src = 16'hFFFF;
                    idle_pct = 51;
                    stall_pct = 0;
                end
                2: begin
                    do src = 16'($urandom);
                    while (src == 0 || src inside {clients});
                    idle_pct = 0;
                    stall_pct = 51;
                end
                default: begin
                    src = 16'h00A5;
                    idle_pct = 30;
                    stall_pct = 30;
                end
            endcase
            write_source(src);
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                random_step(sent);
                n += sent;
                // hold off the sender once per phase until the block is empty
                if (n >= ITEMS_PER_PHASE / 2 && n - sent < ITEMS_PER_PHASE / 2)
                    wait_all_replies();
            end
            wait_all_replies();
        end

        $display("Sent %0d requests over %0d keyboard ids and load mixes", sb.requests,
                 NUM_PHASES + 1);
        $display("Replies: char %0d, wait %0d, fail %0d, key %0d, unknown %0d",
                 sb.status_seen[ST_CHAR], sb.status_seen[ST_WAIT], sb.status_seen[ST_FAIL],
                 sb.status_seen[ST_KEY], sb.status_seen[ST_UNKNOWN]);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout waiting for transactions");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/kbw_pkg.sv
hdl/kbw_ring.sv
hdl/kbw_slot_store.sv
hdl/keystroke_buffer_with_waiters_unit.sv
hdl/kbw_checker.sv
test/tb.sv
